FILE: rtl/core/bii_pkg.sv
// Shared types and constants for the boolean inverted-index query unit.
// Used by the query unit and the emitter in rtl/core; depends on nothing.
package bii_pkg;

    localparam int TERM_W     = 6;
    localparam int DOC_W      = 6;
    localparam int MODE_W     = 2;
    localparam int ROW_MAX    = 64;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [MODE_W-1:0] MODE_IGNORE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REQUIRED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EXCLUDED = 2'd2;

    typedef struct packed {
        logic start;
        logic not_found;
    } emit_cmd_t;

endpackage

FILE: rtl/core/boolean_inverted_index_query_unit.sv
// Boolean inverted-index query unit: posting bitmap RAM, query accumulators, emitter.
// Result path: input registers, S_UPDATE, emitter match register, output word register.
// Throughput: each input word is read from RAM, then updated/written back in S_UPDATE.
// Matches leave one word per cycle from the emitter's match register when not stalled.
// Reset: asynchronous; afterwards a clearing pass zeroes min(TERM_COUNT, 64) rows,
// one per cycle, while no input word is accepted. Depends on bii_pkg, bii_ram, bii_emitter.
module boolean_inverted_index_query_unit
    import bii_pkg::*;
#(
    parameter int TERM_COUNT = 64,
    parameter int DOC_COUNT  = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [5:0] term_index, [11:6] doc_index,
                                                 // [13:12] term_mode, rest zero
    input  logic                  s_axis_tuser,  // [0] func
    input  logic                  s_axis_tlast,  // query_end
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [5:0] found_doc, rest zero
    output logic                  m_axis_tuser,  // [0] not_found
    output logic                  m_axis_tlast   // final_result
);

    // Only the first 2**TERM_W terms can ever be addressed.
    localparam int MEM_DEPTH = (TERM_COUNT < ROW_MAX) ? TERM_COUNT : ROW_MAX;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_UPDATE
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [DOC_COUNT-1:0] req_acc_reg, req_acc_next;
    logic [DOC_COUNT-1:0] exc_acc_reg, exc_acc_next;
    logic                 any_req_reg, any_req_next;

    logic                 func_reg;
    logic [TERM_W-1:0]    term_reg;
    logic [DOC_W-1:0]     doc_reg;
    logic [MODE_W-1:0]    mode_reg;
    logic                 last_reg;

    logic                 accept;
    logic [TERM_W-1:0]    in_term;
    logic                 term_ok;
    logic                 doc_ok;
    logic [DOC_COUNT-1:0] doc_onehot;
    logic [DOC_COUNT-1:0] row;
    logic [DOC_COUNT-1:0] req_q;
    logic [DOC_COUNT-1:0] exc_q;
    logic                 any_q;
    logic [DOC_COUNT-1:0] match;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [DOC_COUNT-1:0] ram_wdata;
    logic [DOC_COUNT-1:0] ram_rdata;

    emit_cmd_t            emit_cmd;
    logic                 emit_busy;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && !emit_busy;
    assign in_term       = s_axis_tdata[TERM_W-1:0];

    // The row is read while the word is accepted and, for a load, written back in the
    // next cycle; the following read can only be issued after that cycle.
    bii_ram #(
        .WIDTH (DOC_COUNT),
        .DEPTH (MEM_DEPTH)
    ) u_postings (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (in_term[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        term_ok = (32'(term_reg) < TERM_COUNT);
        doc_ok  = (32'(doc_reg) < DOC_COUNT);
        for (int i = 0; i < DOC_COUNT; i++)
        begin
            doc_onehot[i] = (doc_reg == DOC_W'(i));
        end
        row   = term_ok ? ram_rdata : '0;
        req_q = req_acc_reg;
        exc_q = exc_acc_reg;
        any_q = any_req_reg;
        case (mode_reg)
            MODE_REQUIRED:
            begin
                req_q = req_acc_reg & row;
                any_q = 1'b1;
            end
            MODE_EXCLUDED:
            begin
                exc_q = exc_acc_reg | row;
            end
            default:
            begin
                req_q = req_acc_reg;
            end
        endcase
        match = any_q ? (req_q & ~exc_q) : '0;
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        req_acc_next = req_acc_reg;
        exc_acc_next = exc_acc_reg;
        any_req_next = any_req_reg;
        ram_we       = 1'b0;
        ram_waddr    = term_reg[AW-1:0];
        ram_wdata    = ram_rdata | doc_onehot;
        emit_cmd     = '0;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_cnt_reg == AW'(MEM_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next = S_IDLE;
                if (func_reg == FUNC_LOAD)
                begin
                    ram_we = term_ok && doc_ok;
                end
                else if (last_reg)
                begin
                    emit_cmd.start     = 1'b1;
                    emit_cmd.not_found = (match == '0);
                    req_acc_next       = '1;
                    exc_acc_next       = '0;
                    any_req_next       = 1'b0;
                end
                else
                begin
                    req_acc_next = req_q;
                    exc_acc_next = exc_q;
                    any_req_next = any_q;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            req_acc_reg <= '1;
            exc_acc_reg <= '0;
            any_req_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            req_acc_reg <= req_acc_next;
            exc_acc_reg <= exc_acc_next;
            any_req_reg <= any_req_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= s_axis_tuser;
            term_reg <= in_term;
            doc_reg  <= s_axis_tdata[TERM_W+DOC_W-1:TERM_W];
            mode_reg <= s_axis_tdata[TERM_W+DOC_W+MODE_W-1:TERM_W+DOC_W];
            last_reg <= s_axis_tlast;
        end
    end

    bii_emitter #(
        .DOC_COUNT (DOC_COUNT)
    ) u_emitter (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (emit_cmd),
        .match         (match),
        .busy          (emit_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit_cmd.start |-> !emit_busy)
        else $error("query finished while the emitter was still busy");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !ram_we)
        else $error("posting RAM written outside clear or update");

    a_query_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (s_axis_tuser == FUNC_QUERY) && s_axis_tlast |-> ##2 emit_busy)
        else $error("query end did not start an emission");

endmodule

FILE: rtl/core/bii_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; used for the posting bitmap store.
module bii_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/bii_emitter.sv
// Result emitter: walks a registered match vector lowest bit first and
// drives the output word register. Depends on bii_pkg.
module bii_emitter
    import bii_pkg::*;
#(
    parameter int DOC_COUNT = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  emit_cmd_t             cmd,
    input  logic [DOC_COUNT-1:0]  match,
    output logic                  busy,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [5:0] found_doc, rest zero
    output logic                  m_axis_tuser,  // [0] not_found
    output logic                  m_axis_tlast   // final_result
);

    logic [DOC_COUNT-1:0]  match_reg, match_next;
    logic                  nf_reg, nf_next;
    logic                  busy_reg, busy_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DOC_W-1:0]      out_doc_reg, out_doc_next;
    logic                  out_nf_reg, out_nf_next;
    logic                  out_last_reg, out_last_next;
    logic [DOC_COUNT-1:0]  low_bit;
    logic [DOC_COUNT-1:0]  remaining;
    logic [DOC_W-1:0]      low_idx;
    logic                  out_free;

    // Isolate the lowest set document and encode its index.
    always_comb
    begin
        low_bit   = match_reg & (~match_reg + 1'b1);
        remaining = match_reg & ~low_bit;
        low_idx   = '0;
        for (int i = 0; i < DOC_COUNT; i++)
        begin
            if (low_bit[i])
            begin
                low_idx = low_idx | DOC_W'(i);
            end
        end
    end

    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        match_next     = match_reg;
        nf_next        = nf_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_doc_next   = out_doc_reg;
        out_nf_next    = out_nf_reg;
        out_last_next  = out_last_reg;
        if (cmd.start)
        begin
            match_next = match;
            nf_next    = cmd.not_found;
            busy_next  = 1'b1;
        end
        else if (busy_reg && out_free)
        begin
            out_valid_next = 1'b1;
            if (nf_reg)
            begin
                out_doc_next  = '0;
                out_nf_next   = 1'b1;
                out_last_next = 1'b1;
                busy_next     = 1'b0;
            end
            else
            begin
                out_doc_next  = low_idx;
                out_nf_next   = 1'b0;
                out_last_next = (remaining == '0);
                match_next    = remaining;
                busy_next     = (remaining != '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_reg    <= match_next;
        nf_reg       <= nf_next;
        out_doc_reg  <= out_doc_next;
        out_nf_reg   <= out_nf_next;
        out_last_reg <= out_last_next;
    end

    assign busy          = busy_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_doc_reg);
    assign m_axis_tuser  = out_nf_reg;
    assign m_axis_tlast  = out_last_reg;

    a_nf_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_nf_reg |-> out_last_reg && (out_doc_reg == '0))
        else $error("not-found word must be final with a zero document");

    a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> busy_reg)
        else $error("emitter did not pick up a start command");

    a_nf_single: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && nf_reg && out_free && !cmd.start |=> !busy_reg)
        else $error("not-found emission took more than one word");

endmodule
